// ----- design/assert_macros.svh -----
// Assertion macros used by the oscillator controller.
// Depends on nothing; each use expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed: next-cycle implication");

`endif

// ----- design/blwo_pkg.sv -----
// Shared constants, codes and controller/datapath link types for the oscillator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package blwo_pkg;

	// Sizing of the table store and the band search
	localparam int TABLE_SIZE  = 1024;
	localparam int MAX_BANDS   = 64;
	localparam int FRAC_BITS   = 16;
	localparam int NUM_TABLES  = 1 + 3 * MAX_BANDS;
	localparam int STORE_DEPTH = TABLE_SIZE * NUM_TABLES;
	localparam int TBL_W       = $clog2(TABLE_SIZE);
	localparam int TSEL_W      = $clog2(NUM_TABLES);
	localparam int STORE_AW    = TSEL_W + TBL_W;
	localparam int BAND_W      = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

	// Field and register widths
	localparam int OP_W       = 2;
	localparam int ADDR_W     = 18;
	localparam int DATA_W     = 16;
	localparam int SAMPLE_W   = 16;
	localparam int LIMIT_W    = 15;
	localparam int PHASE_W    = 32;
	localparam int WAVE_W     = 2;
	localparam int NOTE_W     = 15;
	localparam int CNT_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int PROD_W     = SAMPLE_W + 1 + FRAC_BITS + 1;

	// Stream packing
	localparam int IN_TDATA_W  = 40;
	localparam int IN_TUSER_W  = OP_W;
	localparam int OUT_TDATA_W = SAMPLE_W;

	// Item kinds
	localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
	localparam logic [OP_W-1:0] OP_WAVE_WR = 2'd1;
	localparam logic [OP_W-1:0] OP_BAND_WR = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_CNT  = 2'd3;

	localparam logic [WAVE_W-1:0] WAVE_SINE = 2'd0;

	typedef struct packed {
		logic tick_latch;
		logic wave_wr;
		logic band_wr;
		logic band_clr;
		logic band_rd;
		logic band_step;
		logic tsel_sine;
		logic tsel_band;
		logic rd;
		logic rd_sel_b;
		logic cap_a;
		logic mul;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic sine_only;
		logic band_hit;
		logic band_last;
		logic out_free;
	} sts_t;

endpackage

// ----- design/band_limited_wavetable_oscillator.sv -----
// Band-limited wavetable oscillator: one item at a time; after a tick the next item waits
// until its result is loaded; the single read port of the wave store serves both taps.
// After a register write or a band limit write the next tick first searches the bands,
// one band per read/compare pair, unless sine or no bands are set; writes give no result.
// Reset clears registers, phase and control state; the stores stay undefined until written.
`timescale 1ns / 1ps
module band_limited_wavetable_oscillator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [17:0] addr, [33:18] data, [39:34] zero
	input  logic [blwo_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// [1:0] op
	input  logic [blwo_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
	// Output stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [15:0] sample
	output logic [blwo_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// Register write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [blwo_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [blwo_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import blwo_pkg::*;

	cmd_t                       cmd;
	sts_t                       sts;
	logic                       cfg_fire;
	logic [OP_W-1:0]            in_op;
	logic [ADDR_W-1:0]          in_addr;
	logic signed [DATA_W-1:0]   in_data;
	logic signed [SAMPLE_W-1:0] out_sample;

	// Registers are always writable; a written register holds its new value from the next cycle
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// Unpack the input transfer
	assign in_op   = s_axis_tuser[OP_W-1:0];
	assign in_addr = s_axis_tdata[ADDR_W-1:0];
	assign in_data = signed'(s_axis_tdata[ADDR_W +: DATA_W]);

	// Controller: takes items one at a time and sequences the datapath
	blwo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (in_op),
		.in_ready (s_axis_tready),
		.cfg_fire (cfg_fire),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: stores, phase, interpolation and the output register, which
	// holds a finished sample while the next item is already being taken
	blwo_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_fire   (cfg_fire),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_addr    (in_addr),
		.in_data    (in_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_sample (out_sample)
	);

	assign m_axis_tdata = out_sample;

endmodule

// ----- design/blwo_ctrl.sv -----
// Sequencing controller: item intake, band search steps, table reads, output load.
// Depends on blwo_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module blwo_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [blwo_pkg::OP_W-1:0]  in_op,
	output logic                       in_ready,
	input  logic                       cfg_fire,
	input  blwo_pkg::sts_t             sts,
	output blwo_pkg::cmd_t             cmd
);
	import blwo_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_BRD  = 3'd1;
	localparam logic [2:0] S_BCMP = 3'd2;
	localparam logic [2:0] S_RDA  = 3'd3;
	localparam logic [2:0] S_RDB  = 3'd4;
	localparam logic [2:0] S_MUL  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       cache_valid_q;
	logic       in_fire;
	logic       tick_fire;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign tick_fire = in_fire && (in_op == OP_TICK);

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.wave_wr   = in_fire && (in_op == OP_WAVE_WR);
		cmd.band_wr   = in_fire && (in_op == OP_BAND_WR);
		unique case (state_q)
			S_IDLE: begin
				if (tick_fire) begin
					cmd.tick_latch = 1'b1;
					if (cache_valid_q) begin
						state_d = S_RDA;
					end else if (sts.sine_only) begin
						cmd.tsel_sine = 1'b1;
						state_d       = S_RDA;
					end else begin
						cmd.band_clr = 1'b1;
						state_d      = S_BRD;
					end
				end
			end
			S_BRD: begin
				cmd.band_rd = 1'b1;
				state_d     = S_BCMP;
			end
			S_BCMP: begin
				if (sts.band_hit) begin
					cmd.tsel_band = 1'b1;
					state_d       = S_RDA;
				end else if (sts.band_last) begin
					cmd.tsel_sine = 1'b1;
					state_d       = S_RDA;
				end else begin
					cmd.band_step = 1'b1;
					state_d       = S_BRD;
				end
			end
			S_RDA: begin
				cmd.rd  = 1'b1;
				state_d = S_RDB;
			end
			S_RDB: begin
				cmd.rd       = 1'b1;
				cmd.rd_sel_b = 1'b1;
				cmd.cap_a    = 1'b1;
				state_d      = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Drop the cached table choice whenever a register or a band limit changes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_valid_q <= 1'b0;
		end else if (cfg_fire || cmd.band_wr) begin
			cache_valid_q <= 1'b0;
		end else if (cmd.tsel_sine || cmd.tsel_band) begin
			cache_valid_q <= 1'b1;
		end
	end

	`ASSERT_IMP(a_load_when_free, clk, arst_n, cmd.out_load, sts.out_free)
	`ASSERT_NXT(a_cfg_flush, clk, arst_n, cfg_fire, !cache_valid_q)
	`ASSERT_NXT(a_band_flush, clk, arst_n, cmd.band_wr, !cache_valid_q)
	`ASSERT_NXT(a_tick_busy, clk, arst_n, tick_fire, state_q != S_IDLE)

endmodule

// ----- design/blwo_dp.sv -----
// Datapath: registers, phase accumulator, band limit and wave memories,
// interpolator and output register. Depends on blwo_pkg.
`timescale 1ns / 1ps
module blwo_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  blwo_pkg::cmd_t                      cmd,
	output blwo_pkg::sts_t                      sts,
	input  logic                                cfg_fire,
	input  logic [blwo_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [blwo_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [blwo_pkg::ADDR_W-1:0]         in_addr,
	input  logic signed [blwo_pkg::DATA_W-1:0]  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [blwo_pkg::SAMPLE_W-1:0] out_sample
);
	import blwo_pkg::*;

	logic [WAVE_W-1:0]            waveform_q;
	logic [PHASE_W-1:0]           phase_inc_q;
	logic [NOTE_W-1:0]            note_q;
	logic [CNT_W-1:0]             band_count_q;
	logic [PHASE_W-1:0]           phase_q;
	logic [TBL_W-1:0]             idx_q;
	logic [TBL_W-1:0]             idx_nxt;
	logic [FRAC_BITS-1:0]         frac_q;
	logic [TSEL_W-1:0]            tsel_q;
	logic [TSEL_W-1:0]            tsel_band;
	logic [CNT_W-1:0]             band_cnt_q;
	logic [CNT_W-1:0]             band_n;
	logic [LIMIT_W-1:0]           band_mem [MAX_BANDS];
	logic [LIMIT_W-1:0]           band_rd_q;
	logic signed [SAMPLE_W-1:0]   wave_mem [STORE_DEPTH];
	logic signed [SAMPLE_W-1:0]   rd_q;
	logic signed [SAMPLE_W-1:0]   a_q;
	logic signed [SAMPLE_W:0]     diff;
	logic signed [FRAC_BITS:0]    frac_s;
	logic signed [PROD_W-1:0]     prod_q;
	logic signed [SAMPLE_W-1:0]   interp;
	logic [STORE_AW-1:0]          rd_addr;
	logic                         wave_wr_ok;
	logic                         band_wr_ok;
	logic                         out_valid_q;
	logic signed [SAMPLE_W-1:0]   out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q   <= '0;
			phase_inc_q  <= '0;
			note_q       <= '0;
			band_count_q <= '0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				REG_WAVEFORM:  waveform_q   <= cfg_data[WAVE_W-1:0];
				REG_PHASE_INC: phase_inc_q  <= cfg_data[PHASE_W-1:0];
				REG_NOTE:      note_q       <= cfg_data[NOTE_W-1:0];
				REG_BAND_CNT:  band_count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sample the phase for this tick and advance it, wrapping at the word size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (cmd.tick_latch) begin
			phase_q <= phase_q + phase_inc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_latch) begin
			idx_q  <= phase_q[FRAC_BITS +: TBL_W];
			frac_q <= phase_q[FRAC_BITS-1:0];
		end
	end

	// Band search over the limit memory, one entry per read/compare pair
	assign band_n = (32'(band_count_q) > MAX_BANDS) ? CNT_W'(MAX_BANDS) : band_count_q;
	assign band_wr_ok = (32'(in_addr) < MAX_BANDS);

	always_ff @(posedge clk) begin
		if (cmd.band_clr) begin
			band_cnt_q <= '0;
		end else if (cmd.band_step) begin
			band_cnt_q <= band_cnt_q + CNT_W'(1);
		end
		if (cmd.band_rd) begin
			band_rd_q <= band_mem[band_cnt_q[BAND_W-1:0]];
		end
		if (cmd.band_wr && band_wr_ok) begin
			band_mem[in_addr[BAND_W-1:0]] <= in_data[LIMIT_W-1:0];
		end
	end

	assign tsel_band = TSEL_W'(1 + (32'(waveform_q) - 1) * MAX_BANDS + 32'(band_cnt_q));

	always_ff @(posedge clk) begin
		if (cmd.tsel_sine) begin
			tsel_q <= '0;
		end else if (cmd.tsel_band) begin
			tsel_q <= tsel_band;
		end
	end

	assign sts.sine_only = (waveform_q == WAVE_SINE) || (band_n == '0);
	assign sts.band_hit  = (note_q <= band_rd_q);
	assign sts.band_last = (({1'b0, band_cnt_q} + (CNT_W + 1)'(1)) == {1'b0, band_n});
	assign sts.out_free  = !out_valid_q || out_ready;

	// Wave store: one write port, one registered read port shared by both taps
	assign idx_nxt    = idx_q + TBL_W'(1);
	assign rd_addr    = {tsel_q, (cmd.rd_sel_b ? idx_nxt : idx_q)};
	assign wave_wr_ok = (32'(in_addr) < STORE_DEPTH);

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= wave_mem[rd_addr];
		end
		if (cmd.wave_wr && wave_wr_ok) begin
			wave_mem[STORE_AW'(in_addr)] <= in_data;
		end
	end

	// Linear interpolation; the arithmetic shift floors the scaled difference
	assign diff   = {rd_q[SAMPLE_W-1], rd_q} - {a_q[SAMPLE_W-1], a_q};
	assign frac_s = signed'({1'b0, frac_q});
	assign interp = a_q + SAMPLE_W'(prod_q >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			a_q <= rd_q;
		end
		if (cmd.mul) begin
			prod_q <= diff * frac_s;
		end
		if (cmd.out_load) begin
			out_q <= interp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_q;

endmodule
